>>> design/hsa_pkg.sv
// Shared types and constants for the heat-shield ablation step pipeline.
// No dependencies; imported by every module of the block.
package hsa_pkg;

	localparam int HSA_DIV_STEPS = 64;	// quotient bits per divide
	localparam int HSA_DIV_BPS   = 2;	// quotient bits resolved per stage

	localparam logic [23:0] SIGMA_Q48   = 24'd15960685;	// Stefan-Boltzmann * 2^48
	localparam logic [31:0] THICK_FLOOR = 32'd17;		// about 1e-6 m in Q8.24
	localparam logic [61:0] PWR_MAX     = 62'h2000_0000_0000_0000;	// 2^61

	localparam logic [16:0] EMISSIVITY_RST    = 17'd52429;
	localparam logic [23:0] DENSITY_RST       = 24'd409600;
	localparam logic [31:0] CONDUCTIVITY_RST  = 32'd32768;
	localparam logic [31:0] ABLATION_HEAT_RST = 32'd20000000;
	localparam logic [15:0] SPECIFIC_HEAT_RST = 16'd1500;
	localparam logic [31:0] MAX_TEMP_RST      = 32'd196608000;
	localparam logic [31:0] TIME_STEP_RST     = 32'd2684355;

	typedef enum logic [2:0] {
		REG_EMISSIVITY,
		REG_DENSITY,
		REG_CONDUCTIVITY,
		REG_ABLATION_HEAT,
		REG_SPECIFIC_HEAT,
		REG_MAX_TEMP,
		REG_TIME_STEP
	} hsa_reg_e;

	typedef enum logic [1:0] {
		FM_NONE      = 2'd0,
		FM_EXHAUSTED = 2'd1,
		FM_OVERTEMP  = 2'd2
	} hsa_fm_e;

	typedef struct packed {
		logic [31:0]        thickness_in;
		logic [31:0]        surface_temp_in;
		logic [31:0]        bulk_temp_in;
		logic               failed_in;
		logic [1:0]         fail_code_in;
		logic signed [31:0] heat_flux;
	} hsa_in_t;

	typedef struct packed {
		logic [31:0] thickness_out;
		logic [31:0] surface_temp_out;
		logic [31:0] bulk_temp_out;
		logic        failed_out;
		logic [1:0]  fail_code_out;
	} hsa_out_t;

	// sideband leaving the radiation front end
	typedef struct packed {
		hsa_in_t     item;
		logic [56:0] qr;
		logic        cneg;
	} hsa_front_t;

	// sideband through the ablation and temperature divides
	typedef struct packed {
		hsa_in_t item;
		logic    qneg;
		logic    cneg;
	} hsa_mid_t;

endpackage

>>> design/hsa_div.sv
// Pipelined saturating divider: floor({hi,lo} / c) clamped to 64 bits.
// Depends on hsa_pkg for step counts.
module hsa_div import hsa_pkg::*; #(
	parameter int H  = 8,
	parameter int D  = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [H-1:0]  hi,
	input  logic [63:0]   lo,
	input  logic [D-1:0]  c,
	input  logic [SW-1:0] side_in,
	output logic          v_out,
	output logic [63:0]   q,
	output logic [SW-1:0] side_out
);

	localparam int NST = HSA_DIV_STEPS / HSA_DIV_BPS;
	localparam int W   = (H > D) ? H : D;

	typedef struct packed {
		logic [D-1:0]  rem;
		logic [63:0]   lo;
		logic [63:0]   q;
		logic [D-1:0]  c;
		logic          sat;
		logic          zero;
		logic [SW-1:0] side;
	} st_t;

	logic v_s  [NST+1];
	st_t  st_s [NST+1];

	logic [W-1:0] hi_x, c_x;
	st_t          init;

	function automatic st_t step(input st_t a);
		st_t        r;
		logic [D:0] sh;
		logic [D:0] df;
		r = a;
		for (int b = 0; b < HSA_DIV_BPS; b++) begin
			sh   = {r.rem, r.lo[63]};
			df   = sh - {1'b0, r.c};
			r.lo = {r.lo[62:0], 1'b0};
			if (sh >= {1'b0, r.c}) begin
				r.rem = df[D-1:0];
				r.q   = {r.q[62:0], 1'b1};
			end else begin
				r.rem = sh[D-1:0];
				r.q   = {r.q[62:0], 1'b0};
			end
		end
		return r;
	endfunction

	always_comb begin
		hi_x      = W'(hi);
		c_x       = W'(c);
		init.sat  = (c == '0) || (hi_x >= c_x);
		init.zero = (hi == '0) && (lo == '0);
		init.rem  = init.sat ? '0 : hi_x[D-1:0];
		init.lo   = lo;
		init.q    = '0;
		init.c    = c;
		init.side = side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
			for (int k = 1; k <= NST; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= init;
			for (int k = 1; k <= NST; k++) st_s[k] <= step(st_s[k-1]);
		end
	end

	assign v_out    = v_s[NST];
	assign side_out = st_s[NST].side;
	assign q        = st_s[NST].zero ? '0 : (st_s[NST].sat ? '1 : st_s[NST].q);

endmodule

>>> design/hsa_front.sv
// Front end: radiation loss emissivity*sigma*Ts^4 over seven stages, plus the
// conduction numerator and floored thickness. Depends on hsa_pkg.
module hsa_front import hsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  hsa_in_t     item,
	input  logic [16:0] emissivity,
	input  logic [31:0] conductivity,
	output logic        v_out,
	output hsa_front_t  side,
	output logic [63:0] cp,
	output logic [31:0] tf
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	hsa_in_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7;
	logic cneg_s1, cneg_s2, cneg_s3, cneg_s4, cneg_s5, cneg_s6, cneg_s7;
	logic [63:0] cp_s1, cp_s2, cp_s3, cp_s4, cp_s5, cp_s6, cp_s7;
	logic [31:0] tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6, tf_s7;

	logic [63:0] tsq_s1;
	logic [63:0] pll_s2;
	logic [47:0] plh_s2;
	logic [31:0] phh_s2;
	logic [63:0] qr1_s3;
	logic [55:0] plo_s4, phi_s4;
	logic [55:0] qr2_s5;
	logic [48:0] elo_s6;
	logic [40:0] ehi_s6;
	logic [56:0] qr_s7;

	logic        cneg;
	logic [31:0] ad;
	logic [47:0] sq;
	logic [95:0] sq2;
	logic [87:0] p5;
	logic [72:0] p7;

	always_comb begin
		cneg = item.bulk_temp_in > item.surface_temp_in;
		ad   = cneg ? item.bulk_temp_in - item.surface_temp_in
		            : item.surface_temp_in - item.bulk_temp_in;
		sq   = tsq_s1[63:16];
		sq2  = (96'(phh_s2) << 64) + (96'(plh_s2) << 33) + 96'(pll_s2);
		p5   = (88'(phi_s4) << 32) + 88'(plo_s4);
		p7   = (73'(ehi_s6) << 32) + 73'(elo_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= {v_in, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= item;
			cneg_s1 <= cneg;
			cp_s1   <= 64'(conductivity) * 64'(ad);
			tf_s1   <= (item.thickness_in < THICK_FLOOR) ? THICK_FLOOR : item.thickness_in;
			tsq_s1  <= 64'(item.surface_temp_in) * 64'(item.surface_temp_in);

			// Ts^2 truncated to Q32.16, squared as three partial products
			pll_s2 <= 64'(sq[31:0]) * 64'(sq[31:0]);
			plh_s2 <= 48'(sq[47:32]) * 48'(sq[31:0]);
			phh_s2 <= 32'(sq[47:32]) * 32'(sq[47:32]);

			qr1_s3 <= sq2[95:32];

			plo_s4 <= 56'(qr1_s3[31:0]) * 56'(SIGMA_Q48);
			phi_s4 <= 56'(qr1_s3[63:32]) * 56'(SIGMA_Q48);

			qr2_s5 <= p5[87:32];

			elo_s6 <= 49'(qr2_s5[31:0]) * 49'(emissivity);
			ehi_s6 <= 41'(qr2_s5[55:32]) * 41'(emissivity);

			// stays below 2^57, under the power clamp
			qr_s7 <= p7[72:16];

			{it_s2, it_s3, it_s4, it_s5, it_s6, it_s7} <= {it_s1, it_s2, it_s3, it_s4, it_s5, it_s6};
			{cneg_s2, cneg_s3, cneg_s4, cneg_s5, cneg_s6, cneg_s7} <=
				{cneg_s1, cneg_s2, cneg_s3, cneg_s4, cneg_s5, cneg_s6};
			{cp_s2, cp_s3, cp_s4, cp_s5, cp_s6, cp_s7} <= {cp_s1, cp_s2, cp_s3, cp_s4, cp_s5, cp_s6};
			{tf_s2, tf_s3, tf_s4, tf_s5, tf_s6, tf_s7} <= {tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6};
		end
	end

	assign v_out     = v_s7;
	assign side.item = it_s7;
	assign side.qr   = qr_s7;
	assign side.cneg = cneg_s7;
	assign cp        = cp_s7;
	assign tf        = tf_s7;

endmodule

>>> design/hsa_net.sv
// Net heat q_in - q_rad - q_cond with clamp, then the time-step products and
// the heat-capacity divisor for the next divides. Depends on hsa_pkg.
module hsa_net import hsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  hsa_front_t  side_in,
	input  logic [63:0] qc_raw,
	input  logic [23:0] density,
	input  logic [15:0] specific_heat,
	input  logic [31:0] time_step,
	output logic        v_out,
	output hsa_mid_t    side,
	output logic [92:0] pq,
	output logic [92:0] pc,
	output logic [39:0] rc
);

	logic v_s1, v_s2, v_s3;
	hsa_mid_t md_s1, md_s2, md_s3;
	logic [61:0] qmag_s1, qc_s1;
	logic [63:0] mq_lo_s2, mc_lo_s2;
	logic [61:0] mq_hi_s2, mc_hi_s2;
	logic [39:0] rc_s2, rc_s3;
	logic [92:0] pq_s3, pc_s3;

	logic [61:0]        qc;
	logic signed [63:0] qin, sc, qn, qs;
	logic               qneg;
	logic [63:0]        qabs;

	always_comb begin
		qc   = (qc_raw > 64'(PWR_MAX)) ? PWR_MAX : qc_raw[61:0];
		qin  = {{16{side_in.item.heat_flux[31]}}, side_in.item.heat_flux, 16'd0};
		sc   = side_in.cneg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
		qn   = qin - $signed({7'd0, side_in.qr}) - sc;
		if (qn > $signed({2'b00, PWR_MAX}))
			qs = $signed({2'b00, PWR_MAX});
		else if (qn < -$signed({2'b00, PWR_MAX}))
			qs = -$signed({2'b00, PWR_MAX});
		else
			qs = qn;
		qneg = qs[63];
		qabs = qneg ? 64'(-qs) : 64'(qs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3} <= {v_in, v_s1, v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s1.item <= side_in.item;
			md_s1.qneg <= qneg;
			md_s1.cneg <= side_in.cneg;
			qmag_s1    <= qabs[61:0];
			qc_s1      <= qc;

			mq_lo_s2 <= 64'(qmag_s1[31:0]) * 64'(time_step);
			mq_hi_s2 <= 62'(qmag_s1[61:32]) * 62'(time_step);
			mc_lo_s2 <= 64'(qc_s1[31:0]) * 64'(time_step);
			mc_hi_s2 <= 62'(qc_s1[61:32]) * 62'(time_step);
			rc_s2    <= 40'(density) * 40'(specific_heat);
			md_s2    <= md_s1;

			pq_s3 <= (93'(mq_hi_s2) << 32) + 93'(mq_lo_s2);
			pc_s3 <= (93'(mc_hi_s2) << 32) + 93'(mc_lo_s2);
			rc_s3 <= rc_s2;
			md_s3 <= md_s2;
		end
	end

	assign v_out = v_s3;
	assign side  = md_s3;
	assign pq    = pq_s3;
	assign pc    = pc_s3;
	assign rc    = rc_s3;

endmodule

>>> design/heat_shield_ablation_step_top.sv
// Heat-shield ablation step: top level, config registers and the result stage.
// Depends on hsa_pkg, hsa_front, hsa_div and hsa_net.
//
// Takes one shield cell state plus a heat flux per transaction and returns the
// next state, one transaction per cycle while item_stall is low. The
// latency is set by three chained 64-bit divides (conduction; ablation and
// heat-capacity scaling; thickness normalization), each a 33-stage pipeline
// resolving two quotient bits per stage after its input stage, plus 7 front
// stages for the radiation products, 3 net-heat stages and the output
// register. All stages advance together: item_stall rises only while a
// result is held on a stalled output. Configuration registers should only
// be written with the pipeline empty.
module heat_shield_ablation_step_top import hsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  hsa_in_t     item,
	output logic        result_valid,
	input  logic        result_stall,
	output hsa_out_t    result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FSW = $bits(hsa_front_t);
	localparam int MSW = $bits(hsa_mid_t);

	// config registers
	logic [16:0] emissivity_q;
	logic [23:0] density_q;
	logic [31:0] conductivity_q;
	logic [31:0] ablation_heat_q;
	logic [15:0] specific_heat_q;
	logic [31:0] max_temp_q;
	logic [31:0] time_step_q;

	logic en;

	// front end -> conduction divide
	logic        fr_v;
	hsa_front_t  fr_side;
	logic [63:0] fr_cp;
	logic [31:0] fr_tf;

	logic           da_v;
	logic [63:0]    qc_raw;
	logic [FSW-1:0] da_side_vec;

	// net heat -> divide group B
	logic        nt_v;
	hsa_mid_t    nt_side;
	logic [92:0] nt_pq, nt_pc;
	logic [39:0] nt_rc;

	logic           db_v;
	logic [MSW-1:0] db_side_vec;
	hsa_mid_t       db_side;
	logic [63:0]    a1, dts1, dtb1;

	// divide group C -> result stage
	logic           dc_v;
	logic [MSW-1:0] dc_side_vec;
	hsa_mid_t       dc_side;
	logic [63:0]    dth, dts, dtb;

	hsa_out_t res_d, res_q;
	logic     res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emissivity_q    <= EMISSIVITY_RST;
			density_q       <= DENSITY_RST;
			conductivity_q  <= CONDUCTIVITY_RST;
			ablation_heat_q <= ABLATION_HEAT_RST;
			specific_heat_q <= SPECIFIC_HEAT_RST;
			max_temp_q      <= MAX_TEMP_RST;
			time_step_q     <= TIME_STEP_RST;
		end else if (cfg_we) begin
			case (hsa_reg_e'(cfg_index))
				REG_EMISSIVITY:    emissivity_q    <= cfg_data[16:0];
				REG_DENSITY:       density_q       <= cfg_data[23:0];
				REG_CONDUCTIVITY:  conductivity_q  <= cfg_data;
				REG_ABLATION_HEAT: ablation_heat_q <= cfg_data;
				REG_SPECIFIC_HEAT: specific_heat_q <= cfg_data[15:0];
				REG_MAX_TEMP:      max_temp_q      <= cfg_data;
				REG_TIME_STEP:     time_step_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output holds an untaken transaction
	assign en         = !res_v_q || !result_stall;
	assign item_stall = !en;

	hsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.v_in         (item_valid),
		.item         (item),
		.emissivity   (emissivity_q),
		.conductivity (conductivity_q),
		.v_out        (fr_v),
		.side         (fr_side),
		.cp           (fr_cp),
		.tf           (fr_tf)
	);

	// q_cond = conductivity * |Ts - Tb| * 256 / max(thickness, floor)
	hsa_div #(.H(8), .D(32), .SW(FSW)) u_div_cond (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (fr_v),
		.hi       (fr_cp[63:56]),
		.lo       ({fr_cp[55:0], 8'd0}),
		.c        (fr_tf),
		.side_in  (fr_side),
		.v_out    (da_v),
		.q        (qc_raw),
		.side_out (da_side_vec)
	);

	hsa_net u_net (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.v_in          (da_v),
		.side_in       (hsa_front_t'(da_side_vec)),
		.qc_raw        (qc_raw),
		.density       (density_q),
		.specific_heat (specific_heat_q),
		.time_step     (time_step_q),
		.v_out         (nt_v),
		.side          (nt_side),
		.pq            (nt_pq),
		.pc            (nt_pc),
		.rc            (nt_rc)
	);

	// ablated mass per area: |q_net| * dt / ablation heat
	hsa_div #(.H(29), .D(32), .SW(MSW)) u_div_abl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (nt_v),
		.hi       (nt_pq[92:64]),
		.lo       (nt_pq[63:0]),
		.c        (ablation_heat_q),
		.side_in  (nt_side),
		.v_out    (db_v),
		.q        (a1),
		.side_out (db_side_vec)
	);

	// surface rise before thickness scaling: |q_net| * dt / (rho * c)
	hsa_div #(.H(29), .D(40), .SW(1)) u_div_dts1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (nt_v),
		.hi       (nt_pq[92:64]),
		.lo       (nt_pq[63:0]),
		.c        (nt_rc),
		.side_in  (1'b0),
		.v_out    (),
		.q        (dts1),
		.side_out ()
	);

	// bulk rise before thickness scaling: q_cond * dt / (rho * c)
	hsa_div #(.H(29), .D(40), .SW(1)) u_div_dtb1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (nt_v),
		.hi       (nt_pc[92:64]),
		.lo       (nt_pc[63:0]),
		.c        (nt_rc),
		.side_in  (1'b0),
		.v_out    (),
		.q        (dtb1),
		.side_out ()
	);

	assign db_side = hsa_mid_t'(db_side_vec);

	// thickness loss in Q8.24: mass / (density * 2^12)
	hsa_div #(.H(1), .D(36), .SW(MSW)) u_div_dth (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (db_v),
		.hi       (1'b0),
		.lo       (a1),
		.c        ({density_q, 12'd0}),
		.side_in  (db_side_vec),
		.v_out    (dc_v),
		.q        (dth),
		.side_out (dc_side_vec)
	);

	// surface mass is thickness; 16 scales to Q16.16
	hsa_div #(.H(4), .D(32), .SW(1)) u_div_dts (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (db_v),
		.hi       (dts1[63:60]),
		.lo       ({dts1[59:0], 4'd0}),
		.c        (db_side.item.thickness_in),
		.side_in  (1'b0),
		.v_out    (),
		.q        (dts),
		.side_out ()
	);

	// bulk mass is twice surface mass, hence 8 instead of 16
	hsa_div #(.H(3), .D(32), .SW(1)) u_div_dtb (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (db_v),
		.hi       (dtb1[63:61]),
		.lo       ({dtb1[60:0], 3'd0}),
		.c        (db_side.item.thickness_in),
		.side_in  (1'b0),
		.v_out    (),
		.q        (dtb),
		.side_out ()
	);

	assign dc_side = hsa_mid_t'(dc_side_vec);

	// saturating temperature update, 0 .. 2^32-1
	function automatic logic [31:0] temp_add(input logic [31:0] t, input logic neg,
		input logic [63:0] d);
		logic [31:0] room;
		room = 32'hFFFF_FFFF - t;
		if (neg)
			return (d >= 64'(t)) ? 32'd0 : t - d[31:0];
		return (d >= 64'(room)) ? 32'hFFFF_FFFF : t + d[31:0];
	endfunction

	always_comb begin
		logic [63:0] dth_e;
		logic [31:0] tsn, tbn;
		logic        exh;
		dth_e = dc_side.qneg ? 64'd0 : dth;
		// zero thickness also lands here since any loss >= 0
		exh   = dth_e >= 64'(dc_side.item.thickness_in);
		tsn   = temp_add(dc_side.item.surface_temp_in, dc_side.qneg, dts);
		tbn   = temp_add(dc_side.item.bulk_temp_in, dc_side.cneg, dtb);

		res_d.thickness_out    = dc_side.item.thickness_in;
		res_d.surface_temp_out = dc_side.item.surface_temp_in;
		res_d.bulk_temp_out    = dc_side.item.bulk_temp_in;
		res_d.failed_out       = dc_side.item.failed_in;
		res_d.fail_code_out    = dc_side.item.fail_code_in;

		if (dc_side.item.failed_in) begin
			// already failed: pass through
		end else if (exh) begin
			res_d.thickness_out    = 32'd0;
			res_d.failed_out       = 1'b1;
			res_d.fail_code_out    = FM_EXHAUSTED;
		end else begin
			res_d.thickness_out    = dc_side.item.thickness_in - dth_e[31:0];
			res_d.surface_temp_out = tsn;
			res_d.bulk_temp_out    = tbn;
			if (tsn >= max_temp_q) begin
				res_d.failed_out       = 1'b1;
				res_d.fail_code_out    = FM_OVERTEMP;
			end else begin
				res_d.failed_out       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en) begin
			res_v_q <= dc_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for heat_shield_ablation_step_top.
// Depends on hsa_pkg; predicts each next shield state and compares it in order.

module testbench;
	import hsa_pkg::*;

	// clock, reset and DUT ports
	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	hsa_in_t     item;
	logic        result_valid;
	logic        result_stall;
	hsa_out_t    result;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// testbench copy of the configuration registers
	logic [16:0] emis_q;
	logic [23:0] dens_q;
	logic [31:0] cond_q;
	logic [31:0] abl_heat_q;
	logic [15:0] spec_heat_q;
	logic [31:0] max_temp_q;
	logic [31:0] dt_q;

	hsa_out_t expected_states[$];	// predicted next states, oldest first
	int       error_count;
	bit       tx_idle_en;			// sender idles in random bursts
	bit       rx_idle_en;			// receiver stalls in random bursts
	bit       hold_req;				// ask receiver for one long hold-off
	int       hold_cnt;
	int       stall_burst;

	heat_shield_ablation_step_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// floor(a*b/c) on a 128-bit product, saturating at 2^64-1
	function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
			logic [63:0] c);
		logic [127:0] p;
		logic [127:0] q;
		p = {64'd0, a} * {64'd0, b};
		if (p == 128'd0)
			return 64'd0;
		if (c == 64'd0 || p[127:64] >= c)
			return '1;
		q = p / {64'd0, c};
		return q[63:0];
	endfunction

	function automatic logic [63:0] sat_power(logic [63:0] v);
		return (v > 64'(PWR_MAX)) ? 64'(PWR_MAX) : v;
	endfunction

	// temperature plus or minus a magnitude, clamped to [0, 2^32-1]
	function automatic logic [31:0] temp_shift(logic [31:0] t, logic neg, logic [63:0] d);
		if (neg)
			return (d >= {32'd0, t}) ? 32'd0 : t - d[31:0];
		return (d >= {32'd0, ~t}) ? 32'hFFFF_FFFF : t + d[31:0];
	endfunction

	// next shield state for one cell under the current register copy
	function automatic hsa_out_t next_shield_state(hsa_in_t c);
		hsa_out_t    r;
		logic [63:0] ts, tb, th, sq, qr, qc, ad, tf, qmag, dth, dts, dtb, rc;
		longint      qin, sc, qn;
		logic        cneg, qneg;
		r.thickness_out    = c.thickness_in;
		r.surface_temp_out = c.surface_temp_in;
		r.bulk_temp_out    = c.bulk_temp_in;
		r.failed_out       = c.failed_in;
		r.fail_code_out    = c.fail_code_in;
		if (c.failed_in)
			return r;
		if (c.thickness_in == 32'd0) begin
			r.failed_out       = 1'b1;
			r.fail_code_out    = FM_EXHAUSTED;
			return r;
		end
		ts = {32'd0, c.surface_temp_in};
		tb = {32'd0, c.bulk_temp_in};
		th = {32'd0, c.thickness_in};
		// radiation: Ts^2 kept in Q.16, Ts^4 in whole K^4
		sq = (ts * ts) >> 16;
		qr = scaled_quot(sq, sq, 64'd1 << 32);
		qr = scaled_quot(qr, 64'(SIGMA_Q48), 64'd1 << 32);
		qr = sat_power(scaled_quot(qr, 64'(emis_q), 64'd65536));
		// conduction toward the bulk, thickness floored
		cneg = tb > ts;
		ad   = cneg ? tb - ts : ts - tb;
		tf   = (th < 64'(THICK_FLOOR)) ? 64'(THICK_FLOOR) : th;
		qc   = sat_power(scaled_quot(64'(cond_q) * ad, 64'd256, tf));
		// net heat, clamped to +-2^61
		qin = longint'(c.heat_flux) * 64'sd65536;
		sc  = cneg ? -longint'(qc) : longint'(qc);
		qn  = qin - longint'(qr) - sc;
		if (qn > longint'(PWR_MAX))
			qn = longint'(PWR_MAX);
		if (qn < -longint'(PWR_MAX))
			qn = -longint'(PWR_MAX);
		qneg = qn < 0;
		qmag = qneg ? 64'(-qn) : 64'(qn);
		dth  = 64'd0;
		if (!qneg && qmag != 64'd0)
			dth = scaled_quot(scaled_quot(qmag, 64'(dt_q), 64'(abl_heat_q)), 64'd1,
				64'(dens_q) << 12);
		if (dth >= th) begin
			r.thickness_out    = 32'd0;
			r.failed_out       = 1'b1;
			r.fail_code_out    = FM_EXHAUSTED;
			return r;
		end
		// heat capacity uses thickness before ablation
		rc  = 64'(dens_q) * 64'(spec_heat_q);
		dts = scaled_quot(scaled_quot(qmag, 64'(dt_q), rc), 64'd16, th);
		dtb = scaled_quot(scaled_quot(qc, 64'(dt_q), rc), 64'd8, th);
		r.thickness_out    = c.thickness_in - dth[31:0];
		r.surface_temp_out = temp_shift(c.surface_temp_in, qneg, dts);
		r.bulk_temp_out    = temp_shift(c.bulk_temp_in, cneg, dtb);
		if (r.surface_temp_out >= max_temp_q) begin
			r.failed_out       = 1'b1;
			r.fail_code_out    = FM_OVERTEMP;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Accepted input transactions become predictions; accepted outputs are
	// checked against the oldest prediction.
	always @(posedge clk) begin
		hsa_out_t exp_s;
		if (arst_n && item_valid && !item_stall)
			expected_states.push_back(next_shield_state(item));
		if (arst_n && result_valid && !result_stall) begin
			if (expected_states.size() == 0) begin
				report_mismatch("unexpected result", result.thickness_out, 32'd0);
			end else begin
				exp_s = expected_states.pop_front();
				if (result.thickness_out !== exp_s.thickness_out)
					report_mismatch("thickness", result.thickness_out, exp_s.thickness_out);
				if (result.surface_temp_out !== exp_s.surface_temp_out)
					report_mismatch("surface_temp", result.surface_temp_out,
						exp_s.surface_temp_out);
				if (result.bulk_temp_out !== exp_s.bulk_temp_out)
					report_mismatch("bulk_temp", result.bulk_temp_out, exp_s.bulk_temp_out);
				if (result.failed_out !== exp_s.failed_out)
					report_mismatch("failed", 32'(result.failed_out), 32'(exp_s.failed_out));
				if (result.fail_code_out !== exp_s.fail_code_out)
					report_mismatch("fail_code", 32'(result.fail_code_out),
						32'(exp_s.fail_code_out));
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// pipeline fills and pushes back on the sender.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_req) begin
			hold_req     <= 1'b0;
			hold_cnt     <= 300;
			result_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt     <= hold_cnt - 1;
			result_stall <= 1'b1;
		end else if (stall_burst > 0) begin
			stall_burst  <= stall_burst - 1;
			result_stall <= 1'b1;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			stall_burst  <= $urandom_range(0, 10);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Send one transaction; called at a falling edge, returns at a falling edge.
	// Valid stays high into the next call unless an idle burst is taken.
	task automatic send_cell(hsa_in_t c);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		item_valid = 1'b1;
		item       = c;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted state has come back.
	task automatic drain;
		item_valid = 1'b0;
		while (expected_states.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_reg(hsa_reg_e idx, logic [31:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_EMISSIVITY:    emis_q      = value[16:0];
			REG_DENSITY:       dens_q      = value[23:0];
			REG_CONDUCTIVITY:  cond_q      = value;
			REG_ABLATION_HEAT: abl_heat_q  = value;
			REG_SPECIFIC_HEAT: spec_heat_q = value[15:0];
			REG_MAX_TEMP:      max_temp_q  = value;
			REG_TIME_STEP:     dt_q        = value;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [16:0] em, logic [23:0] de, logic [31:0] co,
			logic [31:0] ah, logic [15:0] sh, logic [31:0] mt, logic [31:0] dt);
		write_reg(REG_EMISSIVITY, 32'(em));
		write_reg(REG_DENSITY, 32'(de));
		write_reg(REG_CONDUCTIVITY, co);
		write_reg(REG_ABLATION_HEAT, ah);
		write_reg(REG_SPECIFIC_HEAT, 32'(sh));
		write_reg(REG_MAX_TEMP, mt);
		write_reg(REG_TIME_STEP, dt);
	endtask

	function automatic hsa_in_t make_cell(logic [31:0] th, logic [31:0] ts, logic [31:0] tb,
			logic fl, logic [1:0] fm, logic [31:0] flux);
		hsa_in_t c;
		c.thickness_in    = th;
		c.surface_temp_in = ts;
		c.bulk_temp_in    = tb;
		c.failed_in       = fl;
		c.fail_code_in    = fm;
		c.heat_flux       = flux;
		return c;
	endfunction

	// Random cell: mostly live cells with plausible content, some noise.
	function automatic hsa_in_t random_cell;
		hsa_in_t c;
		logic [1:0] fm;
		c = make_cell($urandom, $urandom, $urandom, 1'b0, 2'($urandom_range(0, 2)), $urandom);
		case ($urandom_range(0, 9))
			0: c.thickness_in = $urandom_range(0, 40);			// near floor or zero
			1: c.thickness_in = $urandom_range(1, 1 << 16);		// thin, easy to exhaust
			2, 3: c.thickness_in = $urandom_range(1 << 20, 1 << 25);
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: c.heat_flux = $urandom_range(0, 2000000);
			1: c.heat_flux = -$signed(32'($urandom_range(0, 2000000)));
			2: c.surface_temp_in = $urandom_range(0, 3000 << 16);
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			c.bulk_temp_in = c.surface_temp_in + $urandom_range(0, 1 << 20) - (1 << 19);
		if ($urandom_range(0, 11) == 0) begin
			fm = 2'($urandom_range(0, 2));
			c.failed_in       = 1'b1;
			c.fail_code_in    = fm;
		end
		return c;
	endfunction

	task automatic test_directed_cells;
		send_cell(make_cell(32'h0100_0000, 32'h0100_0000, 32'h0080_0000, 1'b1, FM_NONE, 32'd5));
		send_cell(make_cell(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, FM_EXHAUSTED, 32'h8000_0000));
		send_cell(make_cell(32'h1234, 32'hFFFF_FFFF, 32'h0, 1'b1, FM_OVERTEMP, 32'h7FFF_FFFF));
		// zero thickness, live cell
		send_cell(make_cell(32'h0, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, FM_NONE, 32'd1000));
		send_cell(make_cell(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, FM_OVERTEMP, 32'h8000_0000));
		// thickness below and at the floor
		send_cell(make_cell(32'd1, 32'd300 << 16, 32'd290 << 16, 1'b0, FM_NONE, 32'd0));
		send_cell(make_cell(32'd16, 32'd290 << 16, 32'd300 << 16, 1'b0, FM_NONE, -32'sd100));
		send_cell(make_cell(32'd17, 32'd300 << 16, 32'd300 << 16, 1'b0, FM_NONE, 32'd0));
		// thickness and temperature extremes
		send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, FM_NONE,
			32'h7FFF_FFFF));
		send_cell(make_cell(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, FM_NONE, 32'h8000_0000));
		send_cell(make_cell(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, FM_NONE, 32'd0));
		send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, FM_NONE, 32'd0));
		// ordinary re-entry cell, heating and cooling
		send_cell(make_cell(32'h0080_0000, 32'd1200 << 16, 32'd400 << 16, 1'b0, FM_NONE,
			32'd1500000));
		send_cell(make_cell(32'h0080_0000, 32'd1200 << 16, 32'd400 << 16, 1'b0, FM_NONE,
			-32'sd1500000));
		// exhaustion: thin shield under peak flux
		send_cell(make_cell(32'd20, 32'd300 << 16, 32'd300 << 16, 1'b0, FM_NONE, 32'h7FFF_FFFF));
		send_cell(make_cell(32'd1, 32'd0, 32'd0, 1'b0, FM_NONE, 32'd1));
		// over temperature near the default limit
		send_cell(make_cell(32'h0010_0000, 32'd2999 << 16, 32'd2999 << 16, 1'b0, FM_NONE,
			32'd50000000));
		send_cell(make_cell(32'h0100_0000, 32'd3000 << 16, 32'd3000 << 16, 1'b0, FM_NONE,
			32'd0));
		// failure code carried through on a live cell
		send_cell(make_cell(32'h0100_0000, 32'd500 << 16, 32'd500 << 16, 1'b0, FM_EXHAUSTED,
			32'd10));
		send_cell(make_cell(32'h0100_0000, 32'd500 << 16, 32'd500 << 16, 1'b0, FM_OVERTEMP,
			32'd10));
		drain();
	endtask

	task automatic test_random_cells(int n);
		repeat (n)
			send_cell(random_cell());
		drain();
	endtask

	// Register extremes, then random settings, each followed by traffic.
	task automatic test_config_sweep;
		write_all(17'd0, 24'd1, 32'd0, 32'd1, 16'd1, 32'd0, 32'd1);
		test_random_cells(60);
		write_all(17'd65536, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		test_random_cells(60);
		write_all(17'd65536, 24'd1, 32'hFFFF_FFFF, 32'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		test_random_cells(60);
		repeat (4) begin
			write_all(17'($urandom_range(0, 65536)), 24'($urandom_range(1, 24'hFF_FFFF)),
				$urandom, 32'($urandom_range(1, 32'hFFFF_FFFF)),
				16'($urandom_range(1, 16'hFFFF)), $urandom,
				32'($urandom_range(1, 32'hFFFF_FFFF)));
			test_random_cells(60);
		end
		write_all(EMISSIVITY_RST, DENSITY_RST, CONDUCTIVITY_RST, ABLATION_HEAT_RST,
			SPECIFIC_HEAT_RST, MAX_TEMP_RST, TIME_STEP_RST);
	endtask

	// Long receiver hold-off while the sender keeps offering transactions.
	task automatic test_backpressure;
		tx_idle_en = 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		repeat (200)
			send_cell(random_cell());
		tx_idle_en = 1'b1;
		drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_EMISSIVITY;
		cfg_data     = '0;
		result_stall = 1'b0;
		error_count  = 0;
		tx_idle_en   = 1'b1;
		rx_idle_en   = 1'b1;
		hold_req     = 1'b0;
		hold_cnt     = 0;
		stall_burst  = 0;
		emis_q       = EMISSIVITY_RST;
		dens_q       = DENSITY_RST;
		cond_q       = CONDUCTIVITY_RST;
		abl_heat_q   = ABLATION_HEAT_RST;
		spec_heat_q  = SPECIFIC_HEAT_RST;
		max_temp_q   = MAX_TEMP_RST;
		dt_q         = TIME_STEP_RST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		test_directed_cells();		// under reset register values
		test_random_cells(250);
		test_config_sweep();
		test_backpressure();
		// closing stretch with no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_cells(150);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
